// ===== sv/sqe_pkg.sv =====
// ----------------------------------------------------------------------------
// sqe_pkg - shared types and constants of the stack/queue engine
// Item formats, operation and status codes, store geometry, state encodings.
// ----------------------------------------------------------------------------
package sqe_pkg;

  // Store geometry
  localparam int DEPTH = 64;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Command queue between front and back
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  // Operation codes on the input item
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_SWAP = 3'd2;
  localparam logic [2:0] OP_PEEK = 3'd3;
  localparam logic [2:0] OP_DUMP = 3'd4;

  // Status codes on the result item
  localparam logic [2:0] ST_VALUE      = 3'd0;
  localparam logic [2:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [2:0] ST_POP_EMPTY  = 3'd2;
  localparam logic [2:0] ST_SWAP_SHORT = 3'd3;
  localparam logic [2:0] ST_PUSH_FULL  = 3'd4;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_SWAP,
    CMD_PEEK,
    CMD_DUMP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWAP_WR0,
    S_SWAP_WR1,
    S_PEEK,
    S_DUMP
  } back_state_t;

  // Status of the back end, watched at the top level
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } back_stat_t;

endpackage

// ===== sv/sqe_front.sv =====
// ----------------------------------------------------------------------------
// sqe_front - item intake and decode
// Accepts input items, decodes the operation and forwards legal commands.
// ----------------------------------------------------------------------------
module sqe_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sqe_pkg::in_item_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output sqe_pkg::cmd_t    cmd_data
);
  import sqe_pkg::*;

  logic      legal;
  cmd_kind_t kind;
  logic      seen_r;

  // Unused operation codes are taken and dropped here
  always_comb begin
    legal = 1'b1;
    kind  = CMD_PUSH;
    case (in_data.operation)
      OP_PUSH: kind = CMD_PUSH;
      OP_POP:  kind = CMD_POP;
      OP_SWAP: kind = CMD_SWAP;
      OP_PEEK: kind = CMD_PEEK;
      OP_DUMP: kind = CMD_DUMP;
      default: legal = 1'b0;
    endcase
  end

  assign in_ready       = cmd_ready && seen_r;
  assign cmd_valid      = in_valid && legal && seen_r;
  assign cmd_data.kind  = kind;
  assign cmd_data.value = in_data.push_value;

  // Intake opens in the cycle after reset releases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= 1'b1;
    end
  end

endmodule

// ===== sv/sqe_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// sqe_cmd_fifo - command queue
// Short queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
module sqe_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sqe_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output sqe_pkg::cmd_t rd_data
);
  import sqe_pkg::*;

  cmd_t                mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign wr_ready = cnt_r != FQ_CNT_W'(FQ_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/sqe_back.sv =====
// ----------------------------------------------------------------------------
// sqe_back - execution back end
// Holds the circular store, carries out commands, drives the result register.
// ----------------------------------------------------------------------------
module sqe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  sqe_pkg::cmd_t       cmd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sqe_pkg::out_item_t  out_data,
  output sqe_pkg::back_stat_t stat
);
  import sqe_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  back_state_t      state_r, state_nxt;
  logic [PTR_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic             queue_mode_r;
  logic             out_valid_r;
  out_item_t        out_data_r, out_data_nxt;
  logic             out_load;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd0_r, rd1_r;
  logic               rd_en;
  logic [PTR_W-1:0]   raddr0;
  logic               we;
  logic [PTR_W-1:0]   waddr;
  logic signed [31:0] wdata;

  logic             full, empty, too_short, out_free, take, dump_last;
  logic [PTR_W-1:0] slot0, slot1, slot_tail, top_dec, dump_next;
  logic [CNT_W-1:0] idx_ext;

  assign full      = count_r == CNT_W'(DEPTH);
  assign empty     = count_r == '0;
  assign too_short = count_r < CNT_W'(2);
  assign out_free  = !out_valid_r || out_ready;
  assign take      = (state_r == S_IDLE) && cmd_valid && out_free;
  assign slot0     = top_r;
  assign slot1     = slot_add(top_r, CNT_W'(1));
  assign slot_tail = slot_add(top_r, count_r);
  assign top_dec   = (top_r == '0) ? PTR_W'(DEPTH - 1) : top_r - 1'b1;
  assign idx_ext   = CNT_W'(idx_r) + CNT_W'(1);
  assign dump_next = slot_add(top_r, idx_ext);
  assign dump_last = idx_ext == count_r;

  assign cmd_ready  = take;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign stat.count = count_r;
  assign stat.busy  = state_r != S_IDLE;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (cmd_data.kind)
            CMD_SWAP: if (!too_short) state_nxt = S_SWAP_WR0;
            CMD_PEEK: if (!empty) state_nxt = S_PEEK;
            CMD_DUMP: if (!empty) state_nxt = S_DUMP;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SWAP_WR0: state_nxt = S_SWAP_WR1;
      S_SWAP_WR1: state_nxt = S_IDLE;
      S_PEEK:     if (out_free) state_nxt = S_IDLE;
      S_DUMP:     if (out_free && dump_last) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    top_nxt      = top_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    rd_en        = 1'b0;
    raddr0       = slot0;
    we           = 1'b0;
    waddr        = slot0;
    wdata        = rd1_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (cmd_data.kind)
            CMD_PUSH: begin
              if (full) begin
                out_load     = 1'b1;
                out_data_nxt = '{result_value: '0, status: ST_PUSH_FULL, last: 1'b1};
              end else begin
                we        = 1'b1;
                wdata     = cmd_data.value;
                count_nxt = count_r + 1'b1;
                if (queue_mode_r) begin
                  waddr = slot_tail;
                end else begin
                  waddr   = top_dec;
                  top_nxt = top_dec;
                end
              end
            end
            CMD_POP: begin
              if (empty) begin
                out_load     = 1'b1;
                out_data_nxt = '{result_value: '0, status: ST_POP_EMPTY, last: 1'b1};
              end else begin
                top_nxt   = slot1;
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_SWAP: begin
              if (too_short) begin
                out_load     = 1'b1;
                out_data_nxt = '{result_value: '0, status: ST_SWAP_SHORT, last: 1'b1};
              end else begin
                rd_en = 1'b1;
              end
            end
            CMD_PEEK: begin
              if (empty) begin
                out_load     = 1'b1;
                out_data_nxt = '{result_value: '0, status: ST_PEEK_EMPTY, last: 1'b1};
              end else begin
                rd_en = 1'b1;
              end
            end
            CMD_DUMP: begin
              if (!empty) begin
                rd_en   = 1'b1;
                idx_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SWAP_WR0: begin
        we    = 1'b1;
        waddr = slot0;
        wdata = rd1_r;
      end
      S_SWAP_WR1: begin
        we    = 1'b1;
        waddr = slot1;
        wdata = rd0_r;
      end
      S_PEEK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{result_value: rd0_r, status: ST_VALUE, last: 1'b1};
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{result_value: rd0_r, status: ST_VALUE, last: dump_last};
          if (!dump_last) begin
            idx_nxt = idx_r + 1'b1;
            rd_en   = 1'b1;
            raddr0  = dump_next;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      top_r        <= '0;
      count_r      <= '0;
      idx_r        <= '0;
      queue_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) begin
        queue_mode_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd0_r <= mem[raddr0];
      rd1_r <= mem[slot1];
    end
  end

endmodule

// ===== sv/stack_queue_engine_top.sv =====
// ----------------------------------------------------------------------------
// stack_queue_engine_top - stack/queue data store engine
// Deque of signed 32-bit values with push, pop, swap, peek and dump.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake              Payload
//  in_      in   in_valid / in_ready    in_data  (operation, push_value)
//  out_     out  out_valid / out_ready  out_data (result_value, status, last)
//  cfg_     in   cfg_we                 cfg_wdata (queue_mode)
//
//  Back end: push, pop and error results finish as the command is taken;
//  peek reads, then returns; swap reads, then writes both slots; a dump
//  returns one entry per cycle while the result side keeps taking, set
//  by the single store read. Ignored codes, taken at intake, never reach
//  the back end. A two-item command queue lets intake run ahead of execution.
//  Reset (rst_n low, synchronous) empties the store and the queue and
//  clears queue_mode; the store words are not cleared and need no pass.
//  A stalled result holds the back end; intake stalls once the queue fills.
//
module stack_queue_engine_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sqe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sqe_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import sqe_pkg::*;

  // front -> queue
  logic       fq_wr_valid, fq_wr_ready;
  cmd_t       fq_wr_data;
  // queue -> back
  logic       fq_rd_valid, fq_rd_ready;
  cmd_t       fq_rd_data;
  back_stat_t back_stat;

  sqe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_wr_valid),
    .cmd_ready (fq_wr_ready),
    .cmd_data  (fq_wr_data)
  );

  sqe_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_wr_valid),
    .wr_ready (fq_wr_ready),
    .wr_data  (fq_wr_data),
    .rd_valid (fq_rd_valid),
    .rd_ready (fq_rd_ready),
    .rd_data  (fq_rd_data)
  );

  // Execution, store and result register
  sqe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (fq_rd_valid),
    .cmd_ready (fq_rd_ready),
    .cmd_data  (fq_rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (back_stat)
  );

`ifndef ASSERT_OFF
  // Fill count never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.count <= CNT_W'(DEPTH))
    else $error("entry count above store depth");

  // Multi-cycle operations leave the fill count alone
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.busy |=> $stable(back_stat.count))
    else $error("entry count moved during a multi-cycle operation");

  // Error results are final and carry a zero value
  a_err_format: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_VALUE) |->
      (out_data.last && out_data.result_value == '0))
    else $error("malformed error result");

  // Fill count moves by at most one entry a cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (back_stat.count == $past(back_stat.count) ||
              back_stat.count == $past(back_stat.count) + 1'b1 ||
              back_stat.count + 1'b1 == $past(back_stat.count)))
    else $error("entry count jumped");
`endif

endmodule

// ===== tb/tb_stack_queue_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_queue_engine_top - self-checking bench for the stack/queue engine
// A clocked driver feeds command items from a backlog, and a clocked monitor
// checks every result item against a behavioural copy of the store. The run
// covers both push modes, the error paths, a completely full store and a
// long result-side stall that backs the input up.
// ----------------------------------------------------------------------------
module tb_stack_queue_engine_top;
  import sqe_pkg::*;

  // Operation codes the block ignores
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int HOLD_CYCLES   = 160; // long result-side stall
  localparam int SETTLE_CYCLES = 12;  // two queued no-result commands, with margin

  // DUT ports; every input has a known value from time zero
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  // Phase controls, set by the sequencer at a clock edge
  logic no_idle  = 1'b0;  // both sides run flat out
  logic hold_req = 1'b0;  // arm the one long stall of the receiver

  in_item_t  cmd_backlog[$];      // items waiting to be driven
  out_item_t pending_results[$];  // predicted results, oldest first
  int        mismatch_count = 0;

  // Behavioural copy of the store: circular buffer, top slot, live count
  logic signed [31:0] deque_words [DEPTH];
  logic [PTR_W-1:0]   deque_top    = '0;
  logic [CNT_W-1:0]   deque_count  = '0;
  logic               queue_mode_q = 1'b0;

  // Driver and receiver bookkeeping
  int send_gap   = 0;
  int ready_gap  = 0;
  int hold_count = 0;
  bit hold_done  = 1'b0;

  stack_queue_engine_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Mostly back-to-back, sometimes a few cycles, now and then a long gap
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Random word, biased towards the signed extremes
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Slot of the entry that sits 'offset' places below the top (DEPTH is 2^n)
  function automatic logic [PTR_W-1:0] slot_at(int unsigned offset);
    return PTR_W'(deque_top + offset);
  endfunction

  function automatic void expect_result(logic signed [31:0] value, logic [2:0] status,
                                        logic last);
    out_item_t r;
    r.result_value = value;
    r.status       = status;
    r.last         = last;
    pending_results.push_back(r);
  endfunction

  // Applies one accepted command to the store copy and queues what it yields.
  // A failing command yields one error item and leaves the store alone.
  function automatic void apply_command(in_item_t cmd);
    logic signed [31:0] upper;
    case (cmd.operation)
      OP_PUSH: begin
        if (deque_count == CNT_W'(DEPTH)) begin
          expect_result('0, ST_PUSH_FULL, 1'b1);
        end else begin
          if (queue_mode_q) begin
            deque_words[slot_at(deque_count)] = cmd.push_value;
          end else begin
            deque_top = deque_top - 1'b1;
            deque_words[deque_top] = cmd.push_value;
          end
          deque_count = deque_count + 1'b1;
        end
      end
      OP_POP: begin
        if (deque_count == '0) begin
          expect_result('0, ST_POP_EMPTY, 1'b1);
        end else begin
          deque_top   = deque_top + 1'b1;
          deque_count = deque_count - 1'b1;
        end
      end
      OP_SWAP: begin
        if (deque_count < CNT_W'(2)) begin
          expect_result('0, ST_SWAP_SHORT, 1'b1);
        end else begin
          upper = deque_words[slot_at(0)];
          deque_words[slot_at(0)] = deque_words[slot_at(1)];
          deque_words[slot_at(1)] = upper;
        end
      end
      OP_PEEK: begin
        if (deque_count == '0) expect_result('0, ST_PEEK_EMPTY, 1'b1);
        else expect_result(deque_words[slot_at(0)], ST_VALUE, 1'b1);
      end
      OP_DUMP: begin
        // empty store: nothing at all
        for (int i = 0; i < int'(deque_count); i++)
          expect_result(deque_words[slot_at(i)], ST_VALUE, (i + 1) == int'(deque_count));
      end
      default: ; // spare codes are ignored
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents backlog items, holds each until accepted, and feeds the
  // store copy on every accepted item.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) apply_command(in_data);
      // slot is free unless an item is still waiting for ready
      if (!in_valid || in_ready) begin
        if (send_gap != 0 && !no_idle) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (cmd_backlog.size() != 0) begin
          in_data  <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
          send_gap = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off once results start
  // queueing, so the command queue fills and intake stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_gap = 0;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      if (out_valid) hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (ready_gap != 0) begin
      out_ready <= 1'b0;
      ready_gap--;
    end else begin
      out_ready <= 1'b1;
      ready_gap = draw_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d last=%0b",
                                  out_data.result_value, out_data.status, out_data.last));
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value)
          report_mismatch($sformatf("result_value %0d, predicted %0d",
                                    out_data.result_value, want.result_value));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    out_data.status, want.status));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %0b, predicted %0b", out_data.last, want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  task automatic queue_cmd(logic [2:0] op, logic signed [31:0] value);
    in_item_t c;
    c.operation  = op;
    c.push_value = value;
    cmd_backlog.push_back(c);
  endtask

  // Random mix, push-heavy so the store grows and the deeper ops get exercised
  task automatic queue_random(int count);
    int roll;
    logic [2:0] op;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 42)      op = OP_PUSH;
      else if (roll < 62) op = OP_POP;
      else if (roll < 72) op = OP_SWAP;
      else if (roll < 84) op = OP_PEEK;
      else if (roll < 93) op = OP_DUMP;
      else                op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
      queue_cmd(op, pick_word());
    end
  endtask

  // Idle means: backlog drained, last item taken, every result seen, then a
  // few cycles for commands that produce nothing
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(logic mode);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_mode_q = mode;
  endtask

  initial begin
    int fill;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, stack mode: error paths on an empty store, extremes, spare
    // codes, dumps before and after a swap, drain to empty again
    write_mode(1'b0);
    queue_cmd(OP_PEEK, '0);
    queue_cmd(OP_POP, '0);
    queue_cmd(OP_SWAP, '0);
    queue_cmd(OP_DUMP, '0);                 // empty dump: silent
    queue_cmd(OP_PUSH, 32'sh7FFF_FFFF);
    queue_cmd(OP_SWAP, '0);                 // one entry only
    queue_cmd(OP_PEEK, '1);
    queue_cmd(OP_PUSH, 32'sh8000_0000);
    queue_cmd(OP_PUSH, '0);
    queue_cmd(OP_PUSH, '1);
    queue_cmd(OP_DUMP, '0);
    queue_cmd(OP_SWAP, '0);
    queue_cmd(OP_DUMP, '0);
    queue_cmd(OP_SPARE5, 32'shAAAA_AAAA);
    queue_cmd(OP_SPARE6, 32'sh5555_5555);
    queue_cmd(OP_SPARE7, '1);
    queue_cmd(OP_POP, '0);
    queue_cmd(OP_PEEK, '0);
    repeat (4) queue_cmd(OP_POP, '0);       // last one underflows
    queue_cmd(OP_DUMP, '0);
    wait_idle();

    // Queue mode, random traffic
    write_mode(1'b1);
    queue_random(55);
    wait_idle();

    // Still queue mode: fill the store to the brim and overflow it, with the
    // receiver holding off so the command queue backs up behind the errors
    @(posedge clk);
    hold_req <= 1'b1;
    fill = DEPTH - int'(deque_count) + 3;
    repeat (fill) queue_cmd(OP_PUSH, pick_word());
    queue_cmd(OP_DUMP, '0);                 // full-depth dump
    queue_cmd(OP_SWAP, '0);
    queue_cmd(OP_PEEK, '0);
    repeat (40) queue_cmd(OP_POP, '0);
    wait_idle();

    // Back to stack mode, no idling on either side
    write_mode(1'b0);
    @(posedge clk);
    no_idle <= 1'b1;
    queue_random(45);
    wait_idle();
    @(posedge clk);
    no_idle <= 1'b0;

    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                pending_results.size()));
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run (every item a full dump,
  // every result behind the longest receiver gap)
  initial begin
    #25ms;
    $display("FAIL");
    $finish;
  end

endmodule
